@@ src/binary_arithmetic_encoder_macros.svh @@
// assertion macros for the binary arithmetic encoder
// expects clk and rst_n in the scope of the module that includes it
`ifndef BINARY_ARITHMETIC_ENCODER_MACROS_SVH
`define BINARY_ARITHMETIC_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define BAE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder check failed");

// next-cycle implication, disabled during reset
`define BAE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder check failed");

`endif

@@ src/bae_pkg.sv @@
// shared types and constants of the binary arithmetic encoder
// no dependencies
package bae_pkg;

    localparam int unsigned BoundW    = 32;
    localparam int unsigned ProbW     = 16;
    localparam int unsigned ByteW     = 8;
    localparam int unsigned MaxShifts = 4;
    localparam int unsigned IterW     = $clog2(MaxShifts + 1);

    localparam logic [BoundW-1:0] LowReset  = '0;
    localparam logic [BoundW-1:0] HighReset = '1;
    localparam logic [ByteW-1:0]  FillByte  = '1;

    typedef struct packed {
        logic             mode;
        logic [ProbW-1:0] prob_one;
        logic             bit_value;
    } in_word_t;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             last_of_run;
        logic             stream_end;
    } out_word_t;

    typedef struct packed {
        logic             load;
        logic [ProbW-1:0] a;
        logic [ProbW-1:0] b;
    } mul_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_ADD,
        ST_SHIFT,
        ST_FINAL
    } state_t;

endpackage

@@ src/bae_mul.sv @@
// shared 16x16 multiplier with registered product
// depends on bae_pkg
module bae_mul (
    input  logic                                 clk,
    input  bae_pkg::mul_req_t                    req,
    output logic [2*bae_pkg::ProbW-1:0]          product
);

    logic [2*bae_pkg::ProbW-1:0] product_reg;
    logic [2*bae_pkg::ProbW-1:0] product_next;

    always_comb
    begin
        product_next = product_reg;
        if (req.load)
        begin
            product_next = req.a * req.b;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    assign product = product_reg;

endmodule

@@ src/binary_arithmetic_encoder.sv @@
// binary arithmetic encoder: an encode word passes through MUL_HI, MUL_LO, ADD and SHIFT,
// a finish word through SHIFT and FINAL, emitting 1 to 5 bytes; output stalls hold the sequencer.
// both partial products of the split go through one shared 16x16 multiplier in turn,
// and bytes leave one per cycle while the output is not stalled, through a single output register.
// in_ready is high only while the sequencer is idle; rst_n clears the sequencer,
// the output valid and sets the interval to its full width.
`include "binary_arithmetic_encoder_macros.svh"

module binary_arithmetic_encoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bae_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bae_pkg::out_word_t  out_data
);

    bae_pkg::state_t state_reg;
    bae_pkg::state_t state_next;

    logic [bae_pkg::BoundW-1:0] low_reg;
    logic [bae_pkg::BoundW-1:0] low_next;
    logic [bae_pkg::BoundW-1:0] high_reg;
    logic [bae_pkg::BoundW-1:0] high_next;
    logic [bae_pkg::BoundW-1:0] range_reg;
    logic [bae_pkg::BoundW-1:0] range_next;
    logic [bae_pkg::BoundW-1:0] split_reg;
    logic [bae_pkg::BoundW-1:0] split_next;
    logic [bae_pkg::ProbW-1:0]  prob_reg;
    logic [bae_pkg::ProbW-1:0]  prob_next;
    logic                       bit_reg;
    logic                       bit_next;
    logic                       fin_reg;
    logic                       fin_next;
    logic [bae_pkg::IterW-1:0]  iter_reg;
    logic [bae_pkg::IterW-1:0]  iter_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    bae_pkg::out_word_t         out_word_reg;
    bae_pkg::out_word_t         out_word_next;

    bae_pkg::mul_req_t          mul_req;
    logic [bae_pkg::BoundW-1:0] product;
    logic [bae_pkg::BoundW-1:0] split_sum;

    logic in_fire;
    logic out_free;
    logic top_agree;
    logic iter_left;
    logic next_agree;

    bae_mul u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    assign in_ready   = (state_reg == bae_pkg::ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign top_agree  = (low_reg[31:24] == high_reg[31:24]);
    assign iter_left  = (iter_reg != bae_pkg::IterW'(bae_pkg::MaxShifts));
    // after the shift the next top bytes are the current second bytes
    assign next_agree = (low_reg[23:16] == high_reg[23:16]) &&
                        (iter_reg != bae_pkg::IterW'(bae_pkg::MaxShifts - 1));
    assign split_sum  = split_reg + {16'd0, product[31:16]};

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        range_next     = range_reg;
        split_next     = split_reg;
        prob_next      = prob_reg;
        bit_next       = bit_reg;
        fin_next       = fin_reg;
        iter_next      = iter_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_req        = '{load: 1'b0, a: range_reg[31:16], b: prob_reg};

        case (state_reg)
            bae_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    prob_next  = in_data.prob_one;
                    bit_next   = in_data.bit_value;
                    fin_next   = in_data.mode;
                    range_next = high_reg - low_reg;
                    iter_next  = '0;
                    state_next = in_data.mode ? bae_pkg::ST_SHIFT : bae_pkg::ST_MUL_HI;
                end
            end
            bae_pkg::ST_MUL_HI:
            begin
                mul_req    = '{load: 1'b1, a: range_reg[31:16], b: prob_reg};
                state_next = bae_pkg::ST_MUL_LO;
            end
            bae_pkg::ST_MUL_LO:
            begin
                mul_req    = '{load: 1'b1, a: range_reg[15:0], b: prob_reg};
                split_next = low_reg + product;
                state_next = bae_pkg::ST_ADD;
            end
            bae_pkg::ST_ADD:
            begin
                if (bit_reg)
                begin
                    high_next = split_sum;
                end
                else
                begin
                    low_next = split_sum + 32'd1;
                end
                state_next = bae_pkg::ST_SHIFT;
            end
            bae_pkg::ST_SHIFT:
            begin
                if (top_agree && iter_left)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = '{out_byte:    high_reg[31:24],
                                          last_of_run: !fin_reg && !next_agree,
                                          stream_end:  1'b0};
                        low_next       = {low_reg[23:0], 8'd0};
                        high_next      = {high_reg[23:0], bae_pkg::FillByte};
                        iter_next      = iter_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = fin_reg ? bae_pkg::ST_FINAL : bae_pkg::ST_IDLE;
                end
            end
            bae_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '{out_byte:    high_reg[31:24],
                                      last_of_run: 1'b1,
                                      stream_end:  1'b1};
                    low_next       = bae_pkg::LowReset;
                    high_next      = bae_pkg::HighReset;
                    state_next     = bae_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bae_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bae_pkg::ST_IDLE;
            low_reg       <= bae_pkg::LowReset;
            high_reg      <= bae_pkg::HighReset;
            out_valid_reg <= 1'b0;
            fin_reg       <= 1'b0;
            iter_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
            fin_reg       <= fin_next;
            iter_reg      <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg    <= range_next;
        split_reg    <= split_next;
        prob_reg     <= prob_next;
        bit_reg      <= bit_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // interval never collapses or inverts between words
    `BAE_ASSERT_NOW(a_interval_ordered, state_reg == bae_pkg::ST_IDLE, low_reg < high_reg)
    // the end-of-stream byte always closes its run
    `BAE_ASSERT_NOW(a_end_is_last, out_valid_reg && out_word_reg.stream_end,
                    out_word_reg.last_of_run)
    // one word at a time
    `BAE_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
    // a finish word always leaves through the final byte state
    `BAE_ASSERT_NEXT(a_finish_path,
                     state_reg == bae_pkg::ST_SHIFT && fin_reg && !(top_agree && iter_left),
                     state_reg == bae_pkg::ST_FINAL)

endmodule
